FILE: src/rxwd_pkg.sv
package rxwd_pkg;

   localparam int KEY_WORDS  = 16;
   localparam int WORD_W     = 32;
   localparam int ADDR_W     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   // largest key size exponent that still fits the store
   localparam int LG_MAX     = $clog2(KEY_WORDS + 1) - 1;
   // one offset per group of slots that join the key together, plus one never rolled
   localparam int TIER_COUNT = LG_MAX + 2;
   localparam int TIER_W     = $clog2(TIER_COUNT);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic                 OP_DATA     = 1'b0;
   localparam logic                 OP_KEY_LOAD = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SIZE_LOG2 = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLLING_MODE  = 1'd1;

   localparam logic [2:0] FULL_BYTES = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [31:0] word_value;
      logic [3:0]  key_slot;
      logic [2:0]  bytes_valid;
      logic        packet_end;
   } req_type;

   typedef struct packed {
      logic [31:0] plain_word;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [2:0]        lg;
      logic [WORD_W-1:0] amount;
   } roll_upd_type;

   // offset group of a slot: slot 0, slot 1, slots 2..3, slots 4..7 and so on
   function automatic logic [TIER_W-1:0] slot_tier(input logic [ADDR_W-1:0] slot);
      logic [TIER_W-1:0] t;
      t = '0;
      for (int b = 0; b < ADDR_W; b++) begin
         if (slot[b]) begin
            t = TIER_W'(b + 1);
         end
      end
      if (32'(slot) >= (32'd1 << LG_MAX)) begin
         t = TIER_W'(LG_MAX + 1);
      end
      return t;
   endfunction

endpackage

FILE: src/rxwd_ram.sv
module rxwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rxwd_roll.sv
module rxwd_roll (
   input  logic                         clock,
   input  logic                         reset,
   input  rxwd_pkg::roll_upd_type       upd,
   input  logic [rxwd_pkg::TIER_W-1:0]  tier,
   output logic [rxwd_pkg::WORD_W-1:0]  offset
);

   logic [rxwd_pkg::WORD_W-1:0] acc_ff [rxwd_pkg::TIER_COUNT];
   logic [rxwd_pkg::WORD_W-1:0] acc_in [rxwd_pkg::TIER_COUNT];

   // a group joins the roll when the key in use covers it
   always_comb begin
      for (int t = 0; t < rxwd_pkg::TIER_COUNT; t++) begin
         acc_in[t] = acc_ff[t];
         if (upd.en && (t <= 32'(upd.lg)) && (t <= rxwd_pkg::LG_MAX)) begin
            acc_in[t] = acc_ff[t] + upd.amount;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < rxwd_pkg::TIER_COUNT; t++) begin
         if (reset) begin
            acc_ff[t] <= '0;
         end else begin
            acc_ff[t] <= acc_in[t];
         end
      end
   end

   assign offset = acc_ff[tier];

endmodule

FILE: src/rolling_xor_word_decryptor.sv
// Decrypts a stream of 32-bit words one transaction per clock while req_stall is
// low: each data word gives one result, key loads give none. The key words
// live in a 16-entry RAM whose registered read feeds the XOR stage; the rolling
// update is held as a running offset per group of key slots and added on read,
// so a packet end does not stall the stream. The user must make writes to the
// registers only while no transaction is in flight; the block does not enforce it.
module rolling_xor_word_decryptor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rxwd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rxwd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [rxwd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rxwd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [2:0]                    key_size_log2_ff;
   logic                          rolling_mode_ff;
   logic [rxwd_pkg::ADDR_W-1:0]   word_pos_ff, word_pos_in;
   logic [31:0]                   byte_total_ff, byte_total_in;
   logic [rxwd_pkg::KEY_WORDS-1:0] key_valid_ff, key_valid_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic [31:0]                   s1_word_ff;
   logic                          s1_full_ff;
   logic                          s1_last_ff;
   logic [31:0]                   s1_offset_ff;
   logic                          s1_kvalid_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   rxwd_pkg::rsp_type             rsp_data_ff;

   logic                          accept, data_accept, key_accept, s1_advance;
   logic [2:0]                    lg_eff, nbytes;
   logic [rxwd_pkg::ADDR_W-1:0]   mask, rd_idx, wr_slot;
   logic [rxwd_pkg::TIER_W-1:0]   tier;
   logic [31:0]                   offset, total_next, key_raw, key_eff;
   rxwd_pkg::roll_upd_type        upd;

   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign accept      = req_valid && !req_stall;
   assign data_accept = accept && (req_data.opcode == rxwd_pkg::OP_DATA);
   assign key_accept  = accept && (req_data.opcode == rxwd_pkg::OP_KEY_LOAD)
                        && (32'(req_data.key_slot) < rxwd_pkg::KEY_WORDS);

   assign lg_eff  = (32'(key_size_log2_ff) > rxwd_pkg::LG_MAX) ?
                    3'(rxwd_pkg::LG_MAX) : key_size_log2_ff;
   assign mask    = ~({rxwd_pkg::ADDR_W{1'b1}} << lg_eff);
   assign rd_idx  = word_pos_ff & mask;
   assign wr_slot = rxwd_pkg::ADDR_W'(req_data.key_slot);

   assign tier = (req_data.opcode == rxwd_pkg::OP_KEY_LOAD) ?
                 rxwd_pkg::slot_tier(wr_slot) : rxwd_pkg::slot_tier(rd_idx);

   assign nbytes     = (req_data.bytes_valid > rxwd_pkg::FULL_BYTES) ?
                       rxwd_pkg::FULL_BYTES : req_data.bytes_valid;
   assign total_next = byte_total_ff + 32'(nbytes);

   always_comb begin
      upd.en     = data_accept && req_data.packet_end && rolling_mode_ff;
      upd.lg     = lg_eff;
      upd.amount = total_next;
   end

   rxwd_roll u_roll (
      .clock  (clock),
      .reset  (reset),
      .upd    (upd),
      .tier   (tier),
      .offset (offset)
   );

   // keys are stored less the group offset at load time
   rxwd_ram #(
      .WIDTH (32),
      .DEPTH (rxwd_pkg::KEY_WORDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_accept),
      .wr_addr (wr_slot),
      .wr_data (req_data.word_value - offset),
      .rd_en   (data_accept),
      .rd_addr (rd_idx),
      .rd_data (key_raw)
   );

   always_comb begin
      word_pos_in   = word_pos_ff;
      byte_total_in = byte_total_ff;
      key_valid_in  = key_valid_ff;
      if (data_accept) begin
         if (req_data.packet_end) begin
            word_pos_in   = '0;
            byte_total_in = '0;
         end else begin
            word_pos_in   = word_pos_ff + 1'b1;
            byte_total_in = total_next;
         end
      end
      if (key_accept) begin
         key_valid_in[wr_slot] = 1'b1;
      end
      s1_valid_in  = data_accept || (s1_valid_ff && !s1_advance);
      rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_log2_ff <= '0;
         rolling_mode_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            rxwd_pkg::CSR_KEY_SIZE_LOG2: key_size_log2_ff <= csr_wdata;
            rxwd_pkg::CSR_ROLLING_MODE:  rolling_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_pos_ff   <= '0;
         byte_total_ff <= '0;
         key_valid_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_pos_ff   <= word_pos_in;
         byte_total_ff <= byte_total_in;
         key_valid_ff  <= key_valid_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // offset is sampled before this transaction's own packet-end roll lands
   always_ff @(posedge clock) begin
      if (data_accept) begin
         s1_word_ff   <= req_data.word_value;
         s1_full_ff   <= (nbytes == rxwd_pkg::FULL_BYTES);
         s1_last_ff   <= req_data.packet_end;
         s1_offset_ff <= offset;
         s1_kvalid_ff <= key_valid_ff[rd_idx];
      end
   end

   assign key_eff = (s1_kvalid_ff ? key_raw : 32'd0) + s1_offset_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff.plain_word <= s1_full_ff ? (s1_word_ff ^ key_eff) : 32'd0;
         rsp_data_ff.last_out   <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
